// File: rtl/sorted_timer_event_queue_core_assert.svh
// Assertion macros shared by the sorted timer event queue modules.
`ifndef SORTED_TIMER_EVENT_QUEUE_CORE_ASSERT_SVH
`define SORTED_TIMER_EVENT_QUEUE_CORE_ASSERT_SVH

// Assert an implication in the same cycle, disabled during reset.
`define STEQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert an implication in the next cycle, disabled during reset.
`define STEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/steq_pkg.sv
// Shared types and constants of the sorted timer event queue.
`default_nettype none
package steq_pkg;
  localparam int unsigned DefQueueDepth = 32;
  localparam int unsigned MaxResults    = 32;
  localparam int unsigned DelayW        = 31;
  localparam int unsigned IdW           = 8;
  localparam int unsigned CookieW       = 32;
  localparam int unsigned KindW         = 2;

  localparam logic       ActAdd     = 1'b0;
  localparam logic       ActTick    = 1'b1;
  localparam logic [1:0] KindAccept = 2'd0;
  localparam logic [1:0] KindDrop   = 2'd1;
  localparam logic [1:0] KindFired  = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic insert;     // insert the held add item
    logic decrement;  // decrement all nonzero live entries
    logic remove;     // remove the head due entry
  } steq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic full;       // no free cell
    logic due_any;    // a live entry holds zero
    logic due_more;   // more than one live entry holds zero
  } steq_sts_t;
endpackage
`default_nettype wire

// File: rtl/steq_datapath.sv
// Row of queue cells: sorted insert, parallel decrement and compaction.
`default_nettype none
module steq_datapath import steq_pkg::*; #(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire steq_cmd_t          cmd_i,
  input  wire logic [DelayW-1:0]  delay_i,
  input  wire logic [IdW-1:0]     id_i,
  input  wire logic [CookieW-1:0] cookie_i,
  output steq_sts_t               sts_o,
  output logic [IdW-1:0]          head_id_o,
  output logic [CookieW-1:0]      head_cookie_o
);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [DelayW-1:0]  rem_q [QueueDepth];
  logic [IdW-1:0]     id_q  [QueueDepth];
  logic [CookieW-1:0] ck_q  [QueueDepth];
  logic [QueueDepth-1:0] live_q;

  logic [QueueDepth-1:0] due, gt, ins, shift_up, first_due, after_due;
  logic [CntW-1:0] occ;

  // Flag per cell: live, due, larger than the new delay.
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      due[i] = live_q[i] && (rem_q[i] == '0);
      gt[i]  = live_q[i] && (rem_q[i] > delay_i);
    end
  end

  // Locate the first due cell by a prefix chain over the row.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < QueueDepth; i++) begin
      first_due[i] = due[i] && !seen;
      after_due[i] = seen;
      seen = seen | due[i];
    end
  end

  // Insert slot: first larger cell, else the first empty cell; cells above it move up.
  always_comb begin
    logic found;
    found = 1'b0;
    for (int i = 0; i < QueueDepth; i++) begin
      shift_up[i] = found;
      ins[i] = !found && (gt[i] || !live_q[i]);
      found  = found | gt[i] | !live_q[i];
    end
  end

  // Live cells form a prefix, so the top cell tells fullness.
  assign sts_o.full     = live_q[QueueDepth-1];
  assign sts_o.due_any  = |due;
  assign sts_o.due_more = (due & ~first_due) != '0;
  assign occ            = CntW'($countones(live_q));

  // Read the head due cell.
  always_comb begin
    head_id_o     = '0;
    head_cookie_o = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      if (first_due[i]) begin
        head_id_o     = id_q[i];
        head_cookie_o = ck_q[i];
      end
    end
  end

  // Update valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (cmd_i.insert && !sts_o.full) begin
      live_q <= {live_q[QueueDepth-2:0], 1'b1};
    end else if (cmd_i.remove) begin
      live_q <= {1'b0, live_q[QueueDepth-1:1]};
    end
  end

  // Shift, load, decrement or compact the payload cells.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QueueDepth; i++) begin
      if (cmd_i.insert && !sts_o.full) begin
        if (ins[i]) begin
          rem_q[i] <= delay_i;
          id_q[i]  <= id_i;
          ck_q[i]  <= cookie_i;
        end else if (shift_up[i]) begin
          rem_q[i] <= rem_q[(i > 0) ? i - 1 : i];
          id_q[i]  <= id_q[(i > 0) ? i - 1 : i];
          ck_q[i]  <= ck_q[(i > 0) ? i - 1 : i];
        end
      end else if (cmd_i.decrement) begin
        if (rem_q[i] != '0) rem_q[i] <= rem_q[i] - 1'b1;
      end else if (cmd_i.remove) begin
        if ((after_due[i] || first_due[i]) && i < QueueDepth - 1) begin
          rem_q[i] <= rem_q[(i < QueueDepth - 1) ? i + 1 : i];
          id_q[i]  <= id_q[(i < QueueDepth - 1) ? i + 1 : i];
          ck_q[i]  <= ck_q[(i < QueueDepth - 1) ? i + 1 : i];
        end
      end
    end
  end

  `include "sorted_timer_event_queue_core_assert.svh"
  `STEQ_ASSERT_IMP(a_live_prefix, clk_i, rst_ni, 1'b1,
    ((live_q + 1'b1) & live_q) == '0, "live cells not a prefix")
  `STEQ_ASSERT_NEXT(a_remove_one, clk_i, rst_ni, cmd_i.remove && sts_o.due_any,
    occ == $past(occ) - 1'b1, "remove did not drop one cell")
  `STEQ_ASSERT_IMP(a_one_cmd, clk_i, rst_ni, 1'b1,
    $onehot0({cmd_i.insert, cmd_i.decrement, cmd_i.remove}), "overlapping commands")
endmodule
`default_nettype wire

// File: rtl/steq_ctrl.sv
// Controller: sequences add, tick decrement and fired-entry removal.
`default_nettype none
module steq_ctrl import steq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       action_i,
  input  wire steq_sts_t  sts_i,
  output steq_cmd_t       cmd_o,
  output logic            out_load_o,
  output logic [KindW-1:0] out_kind_o,
  output logic            out_last_o,
  output logic            out_fire_o,
  input  wire logic       out_free_i
);
  typedef enum logic [1:0] {StIdle, StScan} state_e;
  localparam int unsigned NW = $clog2(MaxResults + 1);

  state_e state_q, state_d;
  logic [NW-1:0] n_q, n_d;
  logic acc;

  assign in_ready_o = (state_q == StIdle) && out_free_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    out_kind_o = KindAccept;
    out_last_o = 1'b1;
    out_fire_o = 1'b0;
    case (state_q)
      StIdle: begin
        if (acc) begin
          if (action_i == ActAdd) begin
            cmd_o.insert = 1'b1;
            out_load_o   = 1'b1;
            out_kind_o   = sts_i.full ? KindDrop : KindAccept;
          end else begin
            cmd_o.decrement = 1'b1;
            n_d     = '0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        // Emit one due entry a beat, up to the result limit.
        if (!sts_i.due_any || n_q == NW'(MaxResults)) begin
          state_d = StIdle;
        end else if (out_free_i) begin
          cmd_o.remove = 1'b1;
          out_load_o   = 1'b1;
          out_fire_o   = 1'b1;
          out_kind_o   = KindFired;
          out_last_o   = !sts_i.due_more || (n_q == NW'(MaxResults - 1));
          n_d          = n_q + 1'b1;
          if (out_last_o) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

  `include "sorted_timer_event_queue_core_assert.svh"
  `STEQ_ASSERT_IMP(a_load_free, clk_i, rst_ni, out_load_o, out_free_i, "load into busy output")
  `STEQ_ASSERT_IMP(a_limit, clk_i, rst_ni, 1'b1, n_q <= NW'(MaxResults), "result count overrun")
endmodule
`default_nettype wire

// File: rtl/sorted_timer_event_queue_core.sv
// Top level of the sorted timer event queue.
// An add inserts its item and loads its single result beat into the output register.
// A tick decrements, then emits one fired event per beat, up to MaxResults;
// a tick that fires nothing still enters the scan state to see that none is due.
// Input is taken while idle and the output register is free or being drained.
// rst_ni clears the queue to empty and the output register to invalid.
`default_nettype none
module sorted_timer_event_queue_core import steq_pkg::*; #(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // delay[30:0], event_id[38:31], cookie[70:39]
  input  wire logic        s_axis_tuser,  // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // kind[1:0], fired_id[9:2], fired_cookie[41:10]
  output logic             m_axis_tlast
);
  steq_cmd_t cmd;
  steq_sts_t sts;
  logic [IdW-1:0] hid;
  logic [CookieW-1:0] hck;
  logic load, last, fire, free;
  logic [KindW-1:0] kind;
  logic [47:0] data_q;
  logic valid_q, last_q;

  assign free = !valid_q || m_axis_tready;

  steq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .action_i(s_axis_tuser),
    .sts_i(sts), .cmd_o(cmd), .out_load_o(load), .out_kind_o(kind),
    .out_last_o(last), .out_fire_o(fire), .out_free_i(free)
  );

  steq_datapath #(.QueueDepth(QueueDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .delay_i(s_axis_tdata[30:0]), .id_i(s_axis_tdata[38:31]),
    .cookie_i(s_axis_tdata[70:39]),
    .sts_o(sts), .head_id_o(hid), .head_cookie_o(hck)
  );

  // Hold the result beat until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= {6'd0, fire ? hck : CookieW'(0), fire ? hid : IdW'(0), kind};
      last_q <= last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

  `include "sorted_timer_event_queue_core_assert.svh"
  `STEQ_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")
endmodule
`default_nettype wire
